// ===== hw/rtl/catdp_pkg.sv =====
`default_nettype none

package catdp_pkg;

  // Largest index that the scratch table holds.
  localparam int MAX_INDEX = 255;
  localparam int TBL_DEPTH = MAX_INDEX + 1;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);

  // Widths of the payload fields.
  localparam int INDEX_W = 8;
  localparam int VAL_W   = 30;

  // Modulus and its Barrett constant, mu = floor(2^60 / p).
  localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [31:0]      PRIME_W32  = 32'd1000000007;
  localparam logic [31:0]      PRIME_X2   = 32'd2000000014;
  localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

  // Depth of the modular multiply-accumulate pipeline.
  localparam int PIPE_DEPTH = 6;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INIT   = 5'b00010,
    ST_ISSUE  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/catalan_number_dp_mod.sv =====
// Catalan number modulo 1000000007.
//
// Input channel: in_valid, in_index, in_stall. A transfer takes place at a
// clock edge with in_valid high and in_stall low. in_index is the index n;
// an index above the table bound is clamped to the bound.
// Result channel: out_valid, out_value, out_stall. out_value is C(n) mod p.
//
// The block works on one item at a time and holds in_stall high meanwhile.
// It fills a scratch table row by row; each inner step is one modular
// multiply-accumulate issued per cycle into a six-stage pipeline (30x30
// multiply, Barrett quotient, quotient times p, subtract, correct,
// accumulate). A row must drain before the next row reads its entry. A new
// item may be taken while a finished result still waits in the output
// register; the result is only moved there once that register frees.
//
// Reset clears the sequencer and the output valid flag. The scratch table
// is not cleared, since each entry is written before it is read.
`default_nettype none

module catalan_number_dp_mod (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [catdp_pkg::INDEX_W-1:0] in_index,
  output logic                             in_stall,
  output logic                             out_valid,
  output logic [catdp_pkg::VAL_W-1:0]      out_value,
  input  wire logic                        out_stall
);

  import catdp_pkg::*;

  // Control registers.
  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     n_r, n_nxt;
  logic [ADDR_W-1:0]     i_r, i_nxt;
  logic [ADDR_W-1:0]     j_r, j_nxt;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Accumulator, result hold and output register.
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] res_r, res_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  // Scratch table.
  logic [VAL_W-1:0]  mem [TBL_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [VAL_W-1:0]  rd_a_r;
  logic [VAL_W-1:0]  rd_b_r;

  // Pipeline data.
  logic [59:0] prod_r;
  logic [61:0] qm_r;
  logic [31:0] xlo2_r;
  logic [31:0] xlo3_r;
  logic [31:0] qp_r;
  logic [31:0] t_r;
  logic [VAL_W-1:0] t2_r;

  logic        issue;
  logic        in_xfer;
  logic [59:0] qp_full;
  logic [VAL_W:0] acc_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Table read addresses: C[j] and C[i-1-j].
  assign issue  = (state_r == ST_ISSUE);
  assign addr_a = j_r;
  assign addr_b = i_r - j_r - ADDR_W'(1);

  // Table: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Modular multiply pipeline with Barrett reduction.
  assign qp_full = 60'(qm_r[60:31]) * 60'(PRIME);

  always_ff @(posedge clk) begin
    prod_r <= 60'(rd_a_r) * 60'(rd_b_r);
    qm_r   <= 62'(prod_r[59:29]) * 62'(BARRETT_MU);
    xlo2_r <= prod_r[31:0];
    qp_r   <= qp_full[31:0];
    xlo3_r <= xlo2_r;
    t_r    <= xlo3_r - qp_r;
    if (t_r >= PRIME_X2) begin
      t2_r <= VAL_W'(t_r - PRIME_X2);
    end else if (t_r >= PRIME_W32) begin
      t2_r <= VAL_W'(t_r - PRIME_W32);
    end else begin
      t2_r <= VAL_W'(t_r);
    end
  end

  // Modular accumulate of the reduced product.
  assign acc_sum = {1'b0, acc_r} + {1'b0, t2_r};

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    vld_nxt       = {vld_r[PIPE_DEPTH-2:0], issue};
    out_valid_nxt = out_valid_r && out_stall;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    wr_en         = 1'b0;
    wr_addr       = i_r;
    wr_data       = acc_r;

    if (vld_r[PIPE_DEPTH-1]) begin
      if (acc_sum >= {1'b0, PRIME}) begin
        acc_nxt = VAL_W'(acc_sum - {1'b0, PRIME});
      end else begin
        acc_nxt = VAL_W'(acc_sum);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (32'(in_index) > MAX_INDEX) begin
            n_nxt = ADDR_W'(MAX_INDEX);
          end else begin
            n_nxt = ADDR_W'(in_index);
          end
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = VAL_W'(1);
        i_nxt   = ADDR_W'(1);
        j_nxt   = '0;
        acc_nxt = '0;
        if (n_r == '0) begin
          res_nxt   = VAL_W'(1);
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        j_nxt = j_r + ADDR_W'(1);
        if (j_r == i_r - ADDR_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Once the pipeline is empty the row sum is final.
        if (vld_r == '0) begin
          wr_en = 1'b1;
          if (i_r == n_r) begin
            res_nxt   = acc_r;
            state_nxt = ST_FINISH;
          end else begin
            i_nxt     = i_r + ADDR_W'(1);
            j_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_value_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counters and payload.
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTHESIS
  // The pipeline is empty whenever the block waits for a new item.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (vld_r == '0))
    else $error("pipeline busy while idle");

  // The inner index never runs past the row being filled.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> ((j_r < i_r) && (i_r <= n_r)))
    else $error("inner index out of range");

  // The running sum stays reduced after each accumulate.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    $past(vld_r[PIPE_DEPTH-1]) |-> (acc_r < PRIME))
    else $error("accumulator not reduced");

  // A result only appears after the finish step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside finish");

  // A delivered result is a residue.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < PRIME))
    else $error("result out of range");
`endif

endmodule

`default_nettype wire
